// ===== hw/rtl/ctdsr_pkg.sv =====
// ============================================================================
// ctdsr_pkg
// Shared types, codes, widths and the segment table for the clock/date
// seven-segment render block.
// ============================================================================
package ctdsr_pkg;

    // Field widths
    localparam int FUNC_W   = 1;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 7;
    localparam int DOTS_W   = 6;
    localparam int SEG_W    = 8;
    localparam int NUM_DIG  = 6;
    localparam int VAL_W    = 7;   // widest value split into digits (year)
    localparam int BCD_W    = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_FMT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATE_ORDER = 1'b1;

    // Time modes
    localparam logic [1:0] TM_24H       = 2'd0;
    localparam logic [1:0] TM_12H       = 2'd1;
    localparam logic [1:0] TM_12H_BLANK = 2'd2;

    // Date modes
    localparam logic DM_DAY_FIRST   = 1'b0;
    localparam logic DM_MONTH_FIRST = 1'b1;

    // Request functions
    localparam logic FUNC_TIME = 1'b0;
    localparam logic FUNC_DATE = 1'b1;

    localparam logic [SEG_W-1:0]   DOT_BIT   = 8'h01;
    localparam logic [HOUR_W-1:0]  HALF_DAY  = 5'd12;
    localparam logic [DOTS_W-1:0]  DATE_DOTS = 6'b010100;  // after day and month
    localparam logic [BCD_W-1:0]   BLANK_MIN = 4'd10;
    localparam logic [HOUR_W-1:0]  TWO_DIGIT = 5'd10;

    // Segments a..g in bits 7..1, bit 0 is the dot
    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
    };

    typedef struct packed {
        logic                func;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [DOTS_W-1:0]   dot_mask;
    } t_req;

    typedef struct packed {
        logic [1:0] hour_fmt;
        logic       date_order;
    } t_cfg;

    typedef logic [NUM_DIG-1:0][SEG_W-1:0] t_digits;

    // Segment pattern of one decimal digit; anything above nine is blank
    function automatic logic [SEG_W-1:0] seg_of(input logic [BCD_W-1:0] d);
        logic [SEG_W-1:0] s;
        s = '0;
        if (d < BLANK_MIN) begin
            s = SEG_TABLE[d];
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/ctdsr_req_if.sv =====
// ============================================================================
// ctdsr_req_if
// Request channel: valid/ready handshake with time and date fields.
// ============================================================================
interface ctdsr_req_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [ctdsr_pkg::HOUR_W-1:0]        hour;
    logic [ctdsr_pkg::MINUTE_W-1:0]      minute;
    logic [ctdsr_pkg::SECOND_W-1:0]      second;
    logic [ctdsr_pkg::DAY_W-1:0]         day;
    logic [ctdsr_pkg::MONTH_W-1:0]       month;
    logic [ctdsr_pkg::YEAR_W-1:0]        year;
    logic [ctdsr_pkg::DOTS_W-1:0]        dot_mask;

    modport source (
        output valid, func, hour, minute, second, day, month, year, dot_mask,
        input  ready
    );
    modport sink (
        input  valid, func, hour, minute, second, day, month, year, dot_mask,
        output ready
    );
endinterface

// ===== hw/rtl/ctdsr_res_if.sv =====
// ============================================================================
// ctdsr_res_if
// Result channel: valid/ready handshake with six segment bytes.
// ============================================================================
interface ctdsr_res_if;
    logic                          valid;
    logic                          ready;
    logic [ctdsr_pkg::SEG_W-1:0]   digit0;
    logic [ctdsr_pkg::SEG_W-1:0]   digit1;
    logic [ctdsr_pkg::SEG_W-1:0]   digit2;
    logic [ctdsr_pkg::SEG_W-1:0]   digit3;
    logic [ctdsr_pkg::SEG_W-1:0]   digit4;
    logic [ctdsr_pkg::SEG_W-1:0]   digit5;

    modport source (
        output valid, digit0, digit1, digit2, digit3, digit4, digit5,
        input  ready
    );
    modport sink (
        input  valid, digit0, digit1, digit2, digit3, digit4, digit5,
        output ready
    );
endinterface

// ===== hw/rtl/ctdsr_digit_enc.sv =====
// ============================================================================
// ctdsr_digit_enc
// Splits a value into tens and ones and encodes both as segment bytes.
// ============================================================================
module ctdsr_digit_enc (
    input  logic [ctdsr_pkg::VAL_W-1:0] i_value,
    output logic [ctdsr_pkg::SEG_W-1:0] o_ones_seg,
    output logic [ctdsr_pkg::SEG_W-1:0] o_tens_seg
);

    logic [14:0]                   prod;
    logic [ctdsr_pkg::BCD_W-1:0]   tens;
    logic [ctdsr_pkg::VAL_W-1:0]   tens_x10;
    logic [ctdsr_pkg::BCD_W-1:0]   ones;

    // Divide by ten: multiply by 205/2048, exact for every 7-bit input value
    always_comb begin
        prod     = 15'(i_value) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = ctdsr_pkg::VAL_W'({tens, 3'b000}) + ctdsr_pkg::VAL_W'({tens, 1'b0});
        ones     = ctdsr_pkg::BCD_W'(i_value - tens_x10);
    end

    assign o_ones_seg = ctdsr_pkg::seg_of(ones);
    assign o_tens_seg = ctdsr_pkg::seg_of(tens);

endmodule

// ===== hw/rtl/ctdsr_render.sv =====
// ============================================================================
// ctdsr_render
// Combinational render of one request into six segment bytes.
// ============================================================================
module ctdsr_render (
    input  ctdsr_pkg::t_req    i_req,
    input  ctdsr_pkg::t_cfg    i_cfg,
    output ctdsr_pkg::t_digits o_digits
);

    logic [ctdsr_pkg::HOUR_W-1:0]  shown_hr;
    logic [ctdsr_pkg::DAY_W-1:0]   right_val;
    logic [ctdsr_pkg::DAY_W-1:0]   left_val;
    logic [ctdsr_pkg::VAL_W-1:0]   val_lo, val_mid, val_hi;
    logic [ctdsr_pkg::SEG_W-1:0]   lo_one, lo_ten, mid_one, mid_ten, hi_one, hi_ten;
    logic [ctdsr_pkg::DOTS_W-1:0]  dots;
    logic                          is_time;

    assign is_time = (i_req.func == ctdsr_pkg::FUNC_TIME);

    // 12-hour conversion, midnight shown as twelve
    always_comb begin
        shown_hr = i_req.hour;
        if (i_cfg.hour_fmt != ctdsr_pkg::TM_24H) begin
            if (i_req.hour > ctdsr_pkg::HALF_DAY) begin
                shown_hr = i_req.hour - ctdsr_pkg::HALF_DAY;
            end else if (i_req.hour == '0) begin
                shown_hr = ctdsr_pkg::HALF_DAY;
            end
        end
    end

    // Day/month order for dates
    always_comb begin
        if (i_cfg.date_order == ctdsr_pkg::DM_DAY_FIRST) begin
            right_val = ctdsr_pkg::DAY_W'(i_req.month);
            left_val  = i_req.day;
        end else begin
            right_val = i_req.day;
            left_val  = ctdsr_pkg::DAY_W'(i_req.month);
        end
    end

    // Pick the value for each digit pair
    always_comb begin
        if (is_time) begin
            val_lo  = ctdsr_pkg::VAL_W'(i_req.second);
            val_mid = ctdsr_pkg::VAL_W'(i_req.minute);
            val_hi  = ctdsr_pkg::VAL_W'(shown_hr);
            dots    = i_req.dot_mask;
        end else begin
            val_lo  = i_req.year;
            val_mid = ctdsr_pkg::VAL_W'(right_val);
            val_hi  = ctdsr_pkg::VAL_W'(left_val);
            dots    = ctdsr_pkg::DATE_DOTS;
        end
    end

    ctdsr_digit_enc u_enc_lo  (.i_value(val_lo),  .o_ones_seg(lo_one),  .o_tens_seg(lo_ten));
    ctdsr_digit_enc u_enc_mid (.i_value(val_mid), .o_ones_seg(mid_one), .o_tens_seg(mid_ten));
    ctdsr_digit_enc u_enc_hi  (.i_value(val_hi),  .o_ones_seg(hi_one),  .o_tens_seg(hi_ten));

    // Merge dots, then blank the hour tens when leading zero is suppressed
    always_comb begin
        o_digits[0] = lo_one  | {7'b0, dots[0]};
        o_digits[1] = lo_ten  | {7'b0, dots[1]};
        o_digits[2] = mid_one | {7'b0, dots[2]};
        o_digits[3] = mid_ten | {7'b0, dots[3]};
        o_digits[4] = hi_one  | {7'b0, dots[4]};
        o_digits[5] = hi_ten  | {7'b0, dots[5]};
        if (is_time && i_cfg.hour_fmt == ctdsr_pkg::TM_12H_BLANK
                && shown_hr < ctdsr_pkg::TWO_DIGIT) begin
            o_digits[5] = o_digits[5] & ctdsr_pkg::DOT_BIT;
        end
    end

endmodule

// ===== hw/rtl/clock_time_date_segment_render.sv =====
// ============================================================================
// clock_time_date_segment_render
// Renders time or date requests into six seven-segment digit bytes.
// ============================================================================
// Usage:
//   i_req carries one render request per transaction (func selects time or
//   date). o_res returns one transaction per request: digit0 (rightmost)
//   through digit5 (leftmost), segments a..g in bits 7..1, dot in bit 0.
//   i_cfg_we/i_cfg_idx/i_cfg_data write the hour format (index 0) and the
//   date order (index 1); write them only while no request is in flight.
// Path: a request accepted on i_req is captured in the input register,
//   rendered through the digit encoders and loaded into the result
//   register, whose valid bit drives o_res.valid.
// Throughput: one request per cycle while o_res.ready is high. The input
//   register and the result register form a two-stage pipeline; the path
//   between them is set by one divide-by-ten multiplier and a segment table lookup.
// Stall: while o_res.ready is low the result holds; the input register can
//   still take one more request, after which i_req.ready drops.
// Reset: synchronous active-low i_rst_n empties both stages and sets both
//   modes to zero (24-hour, day.month.year).
// ============================================================================
module clock_time_date_segment_render (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ctdsr_req_if.sink                           i_req,
    ctdsr_res_if.source                         o_res,
    input  logic                                i_cfg_we,
    input  logic [ctdsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ctdsr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    ctdsr_pkg::t_cfg    r_cfg;
    ctdsr_pkg::t_req    r_req;
    logic               r_req_valid;
    ctdsr_pkg::t_digits r_digits;
    logic               r_res_valid;
    ctdsr_pkg::t_req    n_req;
    ctdsr_pkg::t_digits n_digits;
    logic               res_ready;
    logic               req_ready;
    logic               req_take;
    logic               res_load;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hour_fmt   <= ctdsr_pkg::TM_24H;
            r_cfg.date_order <= ctdsr_pkg::DM_DAY_FIRST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ctdsr_pkg::CFG_HOUR_FMT:   r_cfg.hour_fmt   <= i_cfg_data;
                ctdsr_pkg::CFG_DATE_ORDER: r_cfg.date_order <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake
    assign res_ready = !r_res_valid || o_res.ready;
    assign req_ready = !r_req_valid || res_ready;
    assign req_take  = i_req.valid && req_ready;
    assign res_load  = r_req_valid && res_ready;
    assign i_req.ready = req_ready;

    always_comb begin
        n_req.func     = i_req.func;
        n_req.hour     = i_req.hour;
        n_req.minute   = i_req.minute;
        n_req.second   = i_req.second;
        n_req.day      = i_req.day;
        n_req.month    = i_req.month;
        n_req.year     = i_req.year;
        n_req.dot_mask = i_req.dot_mask;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (req_ready) begin
            r_req_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req <= n_req;
        end
    end

    ctdsr_render u_render (
        .i_req    (r_req),
        .i_cfg    (r_cfg),
        .o_digits (n_digits)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_ready) begin
            r_res_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_digits <= n_digits;
        end
    end

    assign o_res.valid  = r_res_valid;
    assign o_res.digit0 = r_digits[0];
    assign o_res.digit1 = r_digits[1];
    assign o_res.digit2 = r_digits[2];
    assign o_res.digit3 = r_digits[3];
    assign o_res.digit4 = r_digits[4];
    assign o_res.digit5 = r_digits[5];

    // An accepted transaction always occupies the input register next cycle
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> r_req_valid)
        else $error("accepted request lost before input register");

    // A result only appears from a request held in the input register
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(r_req_valid))
        else $error("result appeared without a request");

    // Date results always carry the fixed day and month dots
    a_date_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load && r_req.func == ctdsr_pkg::FUNC_DATE)
            |=> (o_res.digit2[0] && o_res.digit4[0]))
        else $error("date dots missing");

    // Hour format write lands in the register
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == ctdsr_pkg::CFG_HOUR_FMT)
            |=> r_cfg.hour_fmt == $past(i_cfg_data))
        else $error("time mode write not taken");

endmodule
